>>> rtl/dxt_pkg.sv
package dxt_pkg;

  // format register codes
  localparam logic [1:0] FMT_DXT1 = 2'd0;
  localparam logic [1:0] FMT_DXT3 = 2'd1;
  localparam logic [1:0] FMT_DXT5 = 2'd2;

  localparam logic [1:0] LAST_ROW = 2'd3;
  localparam logic [1:0] TRANSP_IDX = 2'd3;

  typedef struct packed {
    logic [63:0] alpha_bits;
    logic [63:0] color_bits;
  } in_word_t;

  typedef struct packed {
    logic [31:0] texel_0;
    logic [31:0] texel_1;
    logic [31:0] texel_2;
    logic [31:0] texel_3;
    logic [1:0]  row;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    logic [9:0] r;
    logic [9:0] g;
    logic [9:0] b;
  } rgb10_t;

  // unpacked endpoints and weighted sums, ahead of the dividers
  typedef struct packed {
    logic [1:0]        fmt;
    logic              four;
    rgb_t              c0;
    rgb_t              c1;
    rgb_t              half;
    rgb10_t            s2;     // 2*c0 + c1
    rgb10_t            s3;     // c0 + 2*c1
    logic              a_gt;
    logic [7:0]        a0;
    logic [7:0]        a1;
    logic [5:0][10:0]  w7;
    logic [3:0][10:0]  w5;
    logic [63:0]       abits;
    logic [31:0]       idx;
  } unp_t;

  // decoded palette and alpha ramp for one block
  typedef struct packed {
    logic [1:0]       fmt;
    logic             punch;   // three-color mode, index 3 is transparent black
    rgb_t [3:0]       pal;
    logic [7:0][7:0]  ramp;
    logic [63:0]      abits;
    logic [31:0]      idx;
  } blk_t;

  function automatic logic [7:0] expand5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [7:0] expand6(input logic [5:0] v);
    return {v, v[5:4]};
  endfunction

  // x / 3 for x <= 765: x * 683 >> 11
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [20:0] p;
    p = {11'd0, x} * 21'd683;
    return p[18:11];
  endfunction

  // x / 5 for x <= 1275: x * 1639 >> 13
  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [21:0] p;
    p = {11'd0, x} * 22'd1639;
    return p[20:13];
  endfunction

  // x / 7 for x <= 1785: x * 2341 >> 14
  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [22:0] p;
    p = {12'd0, x} * 23'd2341;
    return p[21:14];
  endfunction

endpackage

>>> rtl/dxt_block_decoder_core.sv
// Row 0 of a block reaches out_data through the unpack, interp, block-hold and output
// registers; rows 1..3 follow on the next cycles when out_ready stays high. The row
// serializer sends one row of four texels per cycle while out_ready is high and takes
// a new block as the last row loads; stages A and B take a word per cycle unless held.
// Reset (rst, synchronous): format returns to DXT1, all stages empty, row counter 0.
module dxt_block_decoder_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  dxt_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output dxt_pkg::out_word_t out_data
);
  import dxt_pkg::*;

  // format register: DXT1, DXT3 or DXT5; code 3 decodes as DXT1
  logic [1:0] format;

  // stage A -> B: unpacked endpoints, sums for the palette and alpha ramp
  logic  a_valid;
  logic  a_ready;
  unp_t  a_data;

  // stage B -> serializer: palette, ramp and index bits of one block
  logic  b_valid;
  logic  b_ready;
  blk_t  b_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      format <= FMT_DXT1;
    end else if (cfg_we) begin
      format <= cfg_data;
    end
  end

  // Stage A: 565 expansion, endpoint compare, weighted sums.
  // format is sampled with the word, so it travels with the block.
  dxt_unpack u_unpack (
    .clk      (clk),
    .rst      (rst),
    .fmt      (format),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .dn_valid (a_valid),
    .dn_ready (a_ready),
    .dn_data  (a_data)
  );

  // Stage B: divide by 3, 5 and 7 through reciprocal multiplies,
  // build the four-entry palette and the eight-entry alpha ramp.
  dxt_interp u_interp (
    .clk      (clk),
    .rst      (rst),
    .up_valid (a_valid),
    .up_ready (a_ready),
    .up_data  (a_data),
    .dn_valid (b_valid),
    .dn_ready (b_ready),
    .dn_data  (b_data)
  );

  // Stage C: hold the block, pick four texels per row, drive the output
  // register. A new block is taken as the last row is loaded.
  dxt_rowsel u_rowsel (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (b_valid),
    .up_ready  (b_ready),
    .up_data   (b_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> rtl/dxt_unpack.sv
module dxt_unpack (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        fmt,
  input  logic              in_valid,
  output logic              in_ready,
  input  dxt_pkg::in_word_t in_data,
  output logic              dn_valid,
  input  logic              dn_ready,
  output dxt_pkg::unp_t     dn_data
);
  import dxt_pkg::*;

  logic [15:0] e0;
  logic [15:0] e1;
  logic        dxt1;
  unp_t        unp_next;

  assign e0   = in_data.color_bits[15:0];
  assign e1   = in_data.color_bits[31:16];
  assign dxt1 = (fmt != FMT_DXT3) && (fmt != FMT_DXT5);

  always_comb begin
    logic [8:0] hr, hg, hb;
    unp_next.fmt   = fmt;
    unp_next.four  = !dxt1 || (e0 > e1);
    unp_next.c0    = '{r: expand5(e0[15:11]), g: expand6(e0[10:5]), b: expand5(e0[4:0])};
    unp_next.c1    = '{r: expand5(e1[15:11]), g: expand6(e1[10:5]), b: expand5(e1[4:0])};
    unp_next.s2.r  = {1'b0, unp_next.c0.r, 1'b0} + {2'd0, unp_next.c1.r};
    unp_next.s2.g  = {1'b0, unp_next.c0.g, 1'b0} + {2'd0, unp_next.c1.g};
    unp_next.s2.b  = {1'b0, unp_next.c0.b, 1'b0} + {2'd0, unp_next.c1.b};
    unp_next.s3.r  = {2'd0, unp_next.c0.r} + {1'b0, unp_next.c1.r, 1'b0};
    unp_next.s3.g  = {2'd0, unp_next.c0.g} + {1'b0, unp_next.c1.g, 1'b0};
    unp_next.s3.b  = {2'd0, unp_next.c0.b} + {1'b0, unp_next.c1.b, 1'b0};
    hr = {1'b0, unp_next.c0.r} + {1'b0, unp_next.c1.r};
    hg = {1'b0, unp_next.c0.g} + {1'b0, unp_next.c1.g};
    hb = {1'b0, unp_next.c0.b} + {1'b0, unp_next.c1.b};
    unp_next.half  = '{r: hr[8:1], g: hg[8:1], b: hb[8:1]};
    unp_next.a0    = in_data.alpha_bits[7:0];
    unp_next.a1    = in_data.alpha_bits[15:8];
    unp_next.a_gt  = unp_next.a0 > unp_next.a1;
    for (int k = 1; k <= 6; k++) begin
      unp_next.w7[k-1] = 11'(7 - k) * {3'd0, unp_next.a0} + 11'(k) * {3'd0, unp_next.a1};
    end
    for (int k = 1; k <= 4; k++) begin
      unp_next.w5[k-1] = 11'(5 - k) * {3'd0, unp_next.a0} + 11'(k) * {3'd0, unp_next.a1};
    end
    unp_next.abits = in_data.alpha_bits;
    unp_next.idx   = in_data.color_bits[63:32];
  end

  assign in_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (in_ready) begin
      dn_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      dn_data <= unp_next;
    end
  end

endmodule

>>> rtl/dxt_interp.sv
module dxt_interp (
  input  logic           clk,
  input  logic           rst,
  input  logic           up_valid,
  output logic           up_ready,
  input  dxt_pkg::unp_t  up_data,
  output logic           dn_valid,
  input  logic           dn_ready,
  output dxt_pkg::blk_t  dn_data
);
  import dxt_pkg::*;

  blk_t blk_next;

  always_comb begin
    rgb_t third2;
    rgb_t third3;
    third2 = '{r: div3(up_data.s2.r), g: div3(up_data.s2.g), b: div3(up_data.s2.b)};
    third3 = '{r: div3(up_data.s3.r), g: div3(up_data.s3.g), b: div3(up_data.s3.b)};
    blk_next.fmt    = up_data.fmt;
    blk_next.punch  = !up_data.four;
    blk_next.pal[0] = up_data.c0;
    blk_next.pal[1] = up_data.c1;
    blk_next.pal[2] = up_data.four ? third2 : up_data.half;
    blk_next.pal[3] = up_data.four ? third3 : '0;
    blk_next.ramp[0] = up_data.a0;
    blk_next.ramp[1] = up_data.a1;
    if (up_data.a_gt) begin
      for (int k = 0; k < 6; k++) begin
        blk_next.ramp[k+2] = div7(up_data.w7[k]);
      end
    end else begin
      for (int k = 0; k < 4; k++) begin
        blk_next.ramp[k+2] = div5(up_data.w5[k]);
      end
      blk_next.ramp[6] = 8'd0;
      blk_next.ramp[7] = 8'd255;
    end
    blk_next.abits = up_data.abits;
    blk_next.idx   = up_data.idx;
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      dn_data <= blk_next;
    end
  end

endmodule

>>> rtl/dxt_rowsel.sv
module dxt_rowsel (
  input  logic               clk,
  input  logic               rst,
  input  logic               up_valid,
  output logic               up_ready,
  input  dxt_pkg::blk_t      up_data,
  output logic               out_valid,
  input  logic               out_ready,
  output dxt_pkg::out_word_t out_data
);
  import dxt_pkg::*;

  blk_t        blk;
  logic        blk_valid;
  logic [1:0]  cnt;
  logic        out_load;
  logic [31:0] tex [4];
  out_word_t   row_word;

  assign out_load = blk_valid && (!out_valid || out_ready);
  assign up_ready = !blk_valid || (out_load && cnt == LAST_ROW);

  // one row of four texels from the held block
  always_comb begin
    logic [3:0] ti;
    logic [1:0] ci;
    logic [3:0] nib;
    logic [5:0] apos;
    logic [2:0] sel;
    logic [7:0] alpha;
    for (int j = 0; j < 4; j++) begin
      ti   = {cnt, 2'(j)};
      ci   = blk.idx[{ti, 1'b0} +: 2];
      nib  = blk.abits[{ti, 2'b00} +: 4];
      apos = 6'd16 + {2'd0, ti} + {1'b0, ti, 1'b0};
      sel  = blk.abits[apos +: 3];
      unique case (blk.fmt)
        FMT_DXT3: alpha = {nib, nib};
        FMT_DXT5: alpha = blk.ramp[sel];
        default:  alpha = (blk.punch && ci == TRANSP_IDX) ? 8'd0 : 8'd255;
      endcase
      tex[j] = {alpha, blk.pal[ci]};
    end
    row_word.texel_0 = tex[0];
    row_word.texel_1 = tex[1];
    row_word.texel_2 = tex[2];
    row_word.texel_3 = tex[3];
    row_word.row     = cnt;
    row_word.last    = (cnt == LAST_ROW);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blk_valid <= 1'b0;
      cnt       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (up_valid && up_ready) begin
        blk_valid <= 1'b1;
      end else if (out_load && cnt == LAST_ROW) begin
        blk_valid <= 1'b0;
      end
      if (out_load) begin
        cnt       <= cnt + 2'd1;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      blk <= up_data;
    end
    if (out_load) begin
      out_data <= row_word;
    end
  end

endmodule

>>> test/tb_dxt_block_decoder_core.sv
module tb_dxt_block_decoder_core;
  timeunit 1ns;
  timeprecision 1ps;

  import dxt_pkg::*;

  // The package names only the three meaningful formats; the fourth code
  // decodes as DXT1.
  localparam logic [1:0] FMT_UNDEF = 2'd3;

  localparam int LIMIT_CYCLES = 200000;
  localparam int MAX_REPORTS = 10;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cfg_we = 1'b0;
  logic [1:0] cfg_data = '0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  dxt_block_decoder_core dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Blocks waiting to be sent, and decoded rows waiting to come out.
  in_word_t  pending_blocks[$];
  out_word_t expected_rows[$];

  logic [1:0] fmt_shadow = FMT_DXT1;   // our copy of the format register
  int         mismatches = 0;
  int         cycles = 0;
  bit         send_hold = 1'b0;        // set to make the sender pause
  bit         word_taken = 1'b0;       // input word accepted at the last rising edge
  int         burst_left = 4;
  int         gap_left = 0;
  int         ready_left = 0;

  // ---------------------------------------------------------------------------
  // Texel decode: builds the four rows one block turns into under fmt_shadow.
  // ---------------------------------------------------------------------------
  function automatic void predict_block(in_word_t blk);
    logic [15:0] e0, e1;
    logic [31:0] idx;
    int unsigned c0[3], c1[3];
    logic [31:0] pal[4];
    logic [7:0]  ramp[8];
    logic [31:0] tex[16];
    int unsigned a0, a1, sel;
    bit          colour_only;
    out_word_t   w;

    e0  = blk.color_bits[15:0];
    e1  = blk.color_bits[31:16];
    idx = blk.color_bits[63:32];

    // 565 -> 888 by replicating the top bits into the low bits
    c0[0] = (int'(e0[15:11]) << 3) | (int'(e0[15:11]) >> 2);
    c0[1] = (int'(e0[10:5]) << 2)  | (int'(e0[10:5]) >> 4);
    c0[2] = (int'(e0[4:0]) << 3)   | (int'(e0[4:0]) >> 2);
    c1[0] = (int'(e1[15:11]) << 3) | (int'(e1[15:11]) >> 2);
    c1[1] = (int'(e1[10:5]) << 2)  | (int'(e1[10:5]) >> 4);
    c1[2] = (int'(e1[4:0]) << 3)   | (int'(e1[4:0]) >> 2);

    colour_only = (fmt_shadow != FMT_DXT3) && (fmt_shadow != FMT_DXT5);

    pal[0] = {8'hFF, 8'(c0[0]), 8'(c0[1]), 8'(c0[2])};
    pal[1] = {8'hFF, 8'(c1[0]), 8'(c1[1]), 8'(c1[2])};
    if (colour_only && e0 <= e1) begin
      // three colors plus transparent black
      pal[2] = {8'hFF, 8'((c0[0] + c1[0]) / 2), 8'((c0[1] + c1[1]) / 2),
                8'((c0[2] + c1[2]) / 2)};
      pal[3] = 32'h0000_0000;
    end else begin
      pal[2] = {8'hFF, 8'((2 * c0[0] + c1[0]) / 3), 8'((2 * c0[1] + c1[1]) / 3),
                8'((2 * c0[2] + c1[2]) / 3)};
      pal[3] = {8'hFF, 8'((c0[0] + 2 * c1[0]) / 3), 8'((c0[1] + 2 * c1[1]) / 3),
                8'((c0[2] + 2 * c1[2]) / 3)};
    end

    for (int i = 0; i < 16; i++) tex[i] = pal[idx[2*i +: 2]];

    if (fmt_shadow == FMT_DXT3) begin
      // explicit 4-bit alpha, widened by x17
      for (int i = 0; i < 16; i++)
        tex[i][31:24] = 8'(int'(blk.alpha_bits[4*i +: 4]) * 17);
    end else if (fmt_shadow == FMT_DXT5) begin
      a0 = blk.alpha_bits[7:0];
      a1 = blk.alpha_bits[15:8];
      ramp[0] = 8'(a0);
      ramp[1] = 8'(a1);
      if (a0 > a1) begin
        for (int k = 1; k <= 6; k++) ramp[k+1] = 8'(((7 - k) * a0 + k * a1) / 7);
      end else begin
        for (int k = 1; k <= 4; k++) ramp[k+1] = 8'(((5 - k) * a0 + k * a1) / 5);
        ramp[6] = 8'd0;
        ramp[7] = 8'd255;
      end
      for (int i = 0; i < 16; i++) begin
        sel = blk.alpha_bits[16 + 3*i +: 3];
        tex[i][31:24] = ramp[sel];
      end
    end

    for (int k = 0; k < 4; k++) begin
      w.texel_0 = tex[4*k + 0];
      w.texel_1 = tex[4*k + 1];
      w.texel_2 = tex[4*k + 2];
      w.texel_3 = tex[4*k + 3];
      w.row     = 2'(k);
      w.last    = (k == 3);
      expected_rows.push_back(w);
    end
  endfunction

  // Random block, skewed toward equal endpoints and extreme orderings.
  function automatic in_word_t random_block();
    in_word_t blk;
    blk.alpha_bits = {$urandom, $urandom};
    blk.color_bits = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: blk.color_bits[31:16] = blk.color_bits[15:0];
      1: blk.alpha_bits[15:8] = blk.alpha_bits[7:0];
      2: blk.color_bits[31:0] = $urandom_range(0, 1) ? 32'h0000_FFFF : 32'hFFFF_0000;
      3: blk.alpha_bits[15:0] = $urandom_range(0, 1) ? 16'h00FF : 16'hFF00;
      default: ;
    endcase
    return blk;
  endfunction

  task automatic note_mismatch(string field, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("[%0t] row mismatch in %s: expected %h, got %h", $realtime, field, want, got);
  endtask

  // Fixed blocks: zero and all-ones words, both endpoint orders at the
  // extremes, equal endpoints, alpha endpoints in both orders and equal,
  // and ramp indices that walk through every step.
  task automatic queue_directed();
    in_word_t blk;
    blk.alpha_bits = '0;
    blk.color_bits = '0;
    pending_blocks.push_back(blk);
    blk.alpha_bits = '1;
    blk.color_bits = '1;
    pending_blocks.push_back(blk);
    blk.alpha_bits = {48'hFAC688_FAC688, 8'h00, 8'hFF};
    blk.color_bits = {32'hE4E4_E4E4, 16'h0000, 16'hFFFF};
    pending_blocks.push_back(blk);
    blk.alpha_bits = {48'hFAC688_FAC688, 8'hFF, 8'h00};
    blk.color_bits = {32'h1B1B_1B1B, 16'hFFFF, 16'h0000};
    pending_blocks.push_back(blk);
    blk.alpha_bits = 64'hFEDC_BA98_7654_3210;
    blk.color_bits = {32'hE4E4_E4E4, 16'h07E0, 16'hF81F};
    pending_blocks.push_back(blk);
    blk.alpha_bits = {48'hFAC688_FAC688, 8'h37, 8'hC8};
    blk.color_bits = {32'h1B1B_1B1B, 16'h8410, 16'h8410};
    pending_blocks.push_back(blk);
  endtask

  // Wait until every queued block is in and every row has come back.
  // Checked at the rising edge, where the sender's outputs have settled.
  task automatic settle();
    while (pending_blocks.size() != 0 || in_valid || expected_rows.size() != 0)
      @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Format write; only called with the decoder empty.
  task automatic set_format(logic [1:0] fmt);
    cfg_we   <= 1'b1;
    cfg_data <= fmt;
    @(negedge clk);
    cfg_we   <= 1'b0;
    cfg_data <= '0;
    fmt_shadow = fmt;
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Input side. Acceptance is noted at the rising edge, where the decode of
  // the accepted word is queued; the next word goes out at the falling edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      predict_block(in_data);
      word_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || word_taken) begin
      word_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (!send_hold && pending_blocks.size() != 0) begin
        in_valid <= 1'b1;
        in_data  <= pending_blocks.pop_front();
        burst_left--;
        if (burst_left <= 0) begin
          // end of burst: pick the next burst length and the gap before it
          burst_left = $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
    // else: word still waiting for in_ready, hold valid and payload
  end

  // ---------------------------------------------------------------------------
  // Output side. Ready toggles between runs of its own: short stalls, short
  // ready runs, and now and then a long stretch with no stall at all.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      ready_left = 0;
    end else if (ready_left > 0) begin
      ready_left--;
    end else if (out_ready) begin
      out_ready <= 1'b0;
      ready_left = $urandom_range(0, 5);
    end else begin
      out_ready <= 1'b1;
      ready_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 15);
    end
  end

  // Row checker: each accepted row against the oldest expected one.
  always @(posedge clk) begin
    out_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_rows.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] unexpected output word %h", $realtime, out_data);
      end else begin
        want = expected_rows.pop_front();
        if (out_data.texel_0 !== want.texel_0)
          note_mismatch("texel_0", want.texel_0, out_data.texel_0);
        if (out_data.texel_1 !== want.texel_1)
          note_mismatch("texel_1", want.texel_1, out_data.texel_1);
        if (out_data.texel_2 !== want.texel_2)
          note_mismatch("texel_2", want.texel_2, out_data.texel_2);
        if (out_data.texel_3 !== want.texel_3)
          note_mismatch("texel_3", want.texel_3, out_data.texel_3);
        if (out_data.row !== want.row)
          note_mismatch("row", 32'(want.row), 32'(out_data.row));
        if (out_data.last !== want.last)
          note_mismatch("last", 32'(want.last), 32'(out_data.last));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("FAIL dxt_block_decoder_core");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: directed blocks under each format (the first under the reset
  // value), then random phases that revisit every format.
  // ---------------------------------------------------------------------------
  initial begin
    logic [1:0] phase_fmt[7];
    int         count;

    phase_fmt = '{FMT_DXT5, FMT_DXT1, FMT_DXT3, FMT_UNDEF, FMT_DXT5, FMT_DXT1, FMT_DXT3};

    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    queue_directed();
    settle();
    set_format(FMT_DXT3);
    queue_directed();
    settle();
    set_format(FMT_DXT5);
    queue_directed();
    settle();
    set_format(FMT_UNDEF);
    queue_directed();
    settle();

    for (int p = 0; p < 7; p++) begin
      set_format(phase_fmt[p]);
      count = $urandom_range(20, 36);
      for (int n = 0; n < count; n++) pending_blocks.push_back(random_block());
      if (p == 2) begin
        // mid-phase pause: let the decoder run dry with blocks still queued
        while (pending_blocks.size() > count / 2) @(negedge clk);
        send_hold = 1'b1;
        do @(posedge clk); while (in_valid || expected_rows.size() != 0);
        repeat (3) @(negedge clk);
        send_hold = 1'b0;
      end
      settle();
    end

    repeat (20) @(negedge clk);
    if (mismatches == 0 && expected_rows.size() == 0) begin
      $display("PASS dxt_block_decoder_core");
    end else begin
      $display("FAIL dxt_block_decoder_core");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/dxt_pkg.sv
rtl/dxt_unpack.sv
rtl/dxt_interp.sv
rtl/dxt_rowsel.sv
rtl/dxt_block_decoder_core.sv
test/tb_dxt_block_decoder_core.sv
